// File: hdl/ddkw_pkg.sv
// Package for the discrete delta kernel weight block: widths, register and mode codes,
// shared structs, and the kernel weight tables built at elaboration.
// No dependencies.
package ddkw_pkg;

    localparam int FRAC_BITS = 10;
    localparam int IDX_W     = FRAC_BITS + 1;
    localparam int DEPTH     = 1 << IDX_W;
    localparam int POS_W     = 32;
    localparam int INV_W     = 32;
    localparam int PROD_W    = POS_W + INV_W;
    localparam int WEIGHT_W  = 16;
    localparam int OPT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_OPTION  = 2'd1;

    localparam logic [OPT_W-1:0] OPT_COSINE      = 2'd0;
    localparam logic [OPT_W-1:0] OPT_THREE_POINT = 2'd1;

    localparam logic [INV_W-1:0] INV_CELL_SIZE_RST = 32'd65536;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             in_range;
    } t_dist;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             in_range;
        logic [OPT_W-1:0] option;
    } t_lookup;

    typedef logic [WEIGHT_W-1:0] t_wtab [DEPTH];

    localparam longint          ONE_Q30   = 64'sd1 <<< 30;
    localparam longint unsigned ONE_U     = 64'd1 << 30;
    localparam longint          PI_Q30    = 64'sd3373259426;
    localparam longint          SQRT3_Q30 = 64'sd1859775393;

    function automatic longint unsigned mag64(input longint a);
        return (a < 0) ? (64'd0 - longint'(unsigned'(a))) : longint'(unsigned'(a));
    endfunction

    // unsigned 64-bit quotient by shift and subtract, table build only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo, rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        logic            neg;
        longint unsigned p;
        neg = (a < 0) != (b < 0);
        p = (mag64(a) * mag64(b)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned n_in);
        longint unsigned n, res, bit_v;
        n = n_in;
        res = 64'd0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 64'd0) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint sqrt_q(input longint x);
        if (x <= 0) return 64'sd0;
        return longint'(isqrt64(longint'(unsigned'(x)) << 30));
    endfunction

    function automatic longint cos_q(input longint th);
        longint unsigned t2, term;
        longint          sum;
        t2 = (longint'(unsigned'(th)) * longint'(unsigned'(th))) >> 30;
        term = ONE_U;
        sum = ONE_Q30;
        for (int k = 1; k <= 12; k++) begin
            term = udiv64((term * t2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) != 0) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        return sum;
    endfunction

    function automatic longint asin_q(input longint y);
        longint unsigned x, x2, q, sum, c, d;
        x = mag64(y);
        if (x > ONE_U) x = ONE_U;
        for (int i = 0; i < 2; i++) begin
            x2 = (x * x) >> 30;
            if (x2 > ONE_U) x2 = ONE_U;
            c = isqrt64((ONE_U - x2) << 30);
            d = isqrt64((64'd2 * (ONE_U + c)) << 30);
            x = udiv64(x << 30, d);
        end
        x2 = (x * x) >> 30;
        q = x;
        sum = x;
        for (int n = 1; n <= 12; n++) begin
            q = udiv64(((q * x2) >> 30) * longint'(unsigned'(longint'(2 * n - 1))),
                       64'(2 * n));
            sum = sum + udiv64(q, 64'(2 * n + 1));
        end
        sum = sum * 64'd4;
        return (y < 0) ? -longint'(sum) : longint'(sum);
    endfunction

    function automatic longint cosine_kernel(input int idx);
        int     half, t;
        longint th, c;
        half = 1 << FRAC_BITS;
        t = (idx <= half) ? idx : 2 * half - idx;
        th = longint'((longint'(unsigned'(PI_Q30)) * longint'(unsigned'(longint'(t))))
             >> (FRAC_BITS + 1));
        c = cos_q(th);
        if (idx > half) c = -c;
        return (ONE_Q30 + c) / 4;
    endfunction

    function automatic longint three_point_kernel(input int idx);
        int     half;
        logic   outer;
        longint u, w, s, v, a, k, vs, sa, r;
        half = 1 << FRAC_BITS;
        outer = idx >= half;
        u = longint'(outer ? idx - half : idx) <<< (30 - FRAC_BITS);
        w = mul_q(u, ONE_Q30 - u);
        s = sqrt_q(ONE_Q30 + 12 * w);
        v = 2 * u - ONE_Q30;
        a = asin_q(mul_q(SQRT3_Q30, v) / 2);
        k = mul_q(SQRT3_Q30, PI_Q30) / 108;
        vs = mul_q(v, s);
        sa = mul_q(SQRT3_Q30, a);
        if (!outer) begin
            return (17 * ONE_Q30) / 48 + k + u / 4 - mul_q(u, u) / 4 - vs / 16 - sa / 12;
        end
        r = ONE_Q30 + u;
        return (55 * ONE_Q30) / 48 - k - (13 * r) / 12 + mul_q(r, r) / 4 + vs / 48 + sa / 36;
    endfunction

    function automatic t_wtab build_table(input logic three_pt);
        t_wtab           tab;
        longint          phi;
        longint unsigned wt;
        for (int i = 0; i < DEPTH; i++) begin
            phi = three_pt ? three_point_kernel(i) : cosine_kernel(i);
            wt = 64'd0;
            if (phi > 0) begin
                wt = (longint'(unsigned'(phi)) + 64'd8192) >> 14;
                if (wt > 64'd65535) wt = 64'd65535;
            end
            tab[i] = wt[WEIGHT_W-1:0];
        end
        return tab;
    endfunction

    localparam t_wtab COS_TAB = build_table(1'b0);
    localparam t_wtab TP_TAB  = build_table(1'b1);

endpackage

// File: hdl/discrete_delta_kernel_weight_top.sv
// Top level of the discrete delta kernel weight block: config registers, three-stage
// pipeline with per-stage flow control. Depends on ddkw_pkg, ddkw_dist, ddkw_weight_rom.
//
//  channel  | valid / ready             | payload
//  ---------+---------------------------+----------------------------------
//  input    | i_in_valid / o_in_ready   | i_pos_a, i_pos_b
//  result   | o_out_valid / i_out_ready | o_weight, o_invalid_mode
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the output is not stalled. The stages are the input
// register, distance multiply, and table read into the output register. Each stage
// advances when the one after it is empty or moving, so bubbles close up under an output
// stall. Reset clears the stage valids and sets inv_cell_size to 1.0 and delta_option to
// cosine. Config is always ready.
module discrete_delta_kernel_weight_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ddkw_pkg::POS_W-1:0]      i_pos_a,
    input  logic [ddkw_pkg::POS_W-1:0]      i_pos_b,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ddkw_pkg::WEIGHT_W-1:0]   o_weight,
    output logic                            o_invalid_mode,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ddkw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ddkw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ddkw_pkg::*;

    logic [INV_W-1:0] r_inv_cell_size;
    logic [OPT_W-1:0] r_delta_option;
    logic [POS_W-1:0] r_pos_a, r_pos_b;
    t_lookup          r_lookup;
    logic             r_v1, r_v2, r_v3;
    logic             n_v1, n_v2, n_v3;
    logic             en1, en2, en3;
    t_dist            scaled;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell_size <= INV_CELL_SIZE_RST;
            r_delta_option <= OPT_COSINE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INV_CELL_SIZE: r_inv_cell_size <= i_cfg_data[INV_W-1:0];
                REG_DELTA_OPTION:  r_delta_option <= i_cfg_data[OPT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        en3 = !r_v3 || i_out_ready;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
        n_v1 = en1 ? i_in_valid : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
        n_v3 = en3 ? r_v2 : r_v3;
    end

    assign o_in_ready = en1;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pos_a <= i_pos_a;
            r_pos_b <= i_pos_b;
        end
        if (en2) begin
            r_lookup.idx <= scaled.idx;
            r_lookup.in_range <= scaled.in_range;
            r_lookup.option <= r_delta_option;
        end
    end

    ddkw_dist u_dist (
        .i_pos_a         (r_pos_a),
        .i_pos_b         (r_pos_b),
        .i_inv_cell_size (r_inv_cell_size),
        .o_dist          (scaled)
    );

    ddkw_weight_rom u_rom (
        .i_clk          (i_clk),
        .i_en           (en3),
        .i_lookup       (r_lookup),
        .o_weight       (o_weight),
        .o_invalid_mode (o_invalid_mode)
    );

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalid_mode) |-> (o_weight == '0))
        else $error("invalid mode result with nonzero weight");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input blocked with a stage empty");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !r_v1 && !r_v2 && !r_v3) |-> ##3 o_out_valid)
        else $error("beat did not reach output in three cycles");

endmodule

// File: hdl/ddkw_dist.sv
// Scaled distance: |a - b| times the reciprocal cell size, split into table index and
// support flag. Combinational. Depends on ddkw_pkg.
module ddkw_dist (
    input  logic [ddkw_pkg::POS_W-1:0] i_pos_a,
    input  logic [ddkw_pkg::POS_W-1:0] i_pos_b,
    input  logic [ddkw_pkg::INV_W-1:0] i_inv_cell_size,
    output ddkw_pkg::t_dist            o_dist
);
    import ddkw_pkg::*;

    logic signed [POS_W:0] diff;
    logic [POS_W-1:0]      mag;
    logic [PROD_W-1:0]     prod;

    always_comb begin
        diff = $signed({i_pos_a[POS_W-1], i_pos_a}) - $signed({i_pos_b[POS_W-1], i_pos_b});
        mag = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
        prod = PROD_W'(mag) * PROD_W'(i_inv_cell_size);
        o_dist.in_range = (prod[PROD_W-1:33] == '0);
        o_dist.idx = prod[32:32-FRAC_BITS];
    end

endmodule

// File: hdl/ddkw_weight_rom.sv
// Kernel weight lookup with registered output: cosine and three-point tables,
// zero outside support, flag on invalid mode. Depends on ddkw_pkg.
module ddkw_weight_rom (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  ddkw_pkg::t_lookup             i_lookup,
    output logic [ddkw_pkg::WEIGHT_W-1:0] o_weight,
    output logic                          o_invalid_mode
);
    import ddkw_pkg::*;

    logic [WEIGHT_W-1:0] r_weight;
    logic                r_invalid_mode;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (i_lookup.option)
                OPT_COSINE: begin
                    r_weight <= i_lookup.in_range ? COS_TAB[i_lookup.idx] : '0;
                    r_invalid_mode <= 1'b0;
                end
                OPT_THREE_POINT: begin
                    r_weight <= i_lookup.in_range ? TP_TAB[i_lookup.idx] : '0;
                    r_invalid_mode <= 1'b0;
                end
                default: begin
                    r_weight <= '0;
                    r_invalid_mode <= 1'b1;
                end
            endcase
        end
    end

    assign o_weight = r_weight;
    assign o_invalid_mode = r_invalid_mode;

endmodule
